/* hdl/pdl_pkg.sv */
// shared constants, widths and types for the line follower rate controller
// no dependencies; imported by pdl_mul, pdl_div and pd_line_follow_step_rate
package pdl_pkg;

  localparam int CLOCK_RATE = 2000000;
  localparam int FRAC_BITS  = 20;

  localparam int LEVEL_W  = 12;
  localparam int GAIN_W   = 20;
  localparam int ERR_W    = 13;
  localparam int DIFF_W   = 14;
  localparam int CORR_W   = 35;
  localparam int CORR_LO_W = 18;
  localparam int ACC_W    = 48;
  localparam int RAW_W    = ACC_W - FRAC_BITS;
  localparam int PERIOD_W = 16;
  localparam int HIGH_W   = 15;

  localparam int MUL_A_W = 22;
  localparam int MUL_B_W = 19;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int DIV_W     = $clog2(CLOCK_RATE + 1);
  localparam int DIV_STEPS = (DIV_W + 1) / 2;
  localparam int DIV_PAD   = 2 * DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_CENTRE_TARGET = 3'd0;
  localparam logic [2:0] REG_LEFT_TARGET   = 3'd1;
  localparam logic [2:0] REG_RIGHT_TARGET  = 3'd2;
  localparam logic [2:0] REG_PROP_GAIN     = 3'd3;
  localparam logic [2:0] REG_DERIV_GAIN    = 3'd4;
  localparam logic [2:0] REG_CRUISE_RATE   = 3'd5;
  localparam logic [2:0] REG_LOWEST_RATE   = 3'd6;
  localparam logic [2:0] REG_HIGHEST_RATE  = 3'd7;

  typedef logic [LEVEL_W-1:0] rate_t;

  typedef struct packed {
    logic  start;
    rate_t divisor;
  } div_cmd_t;

  typedef struct packed {
    logic                done;
    logic [PERIOD_W-1:0] period;
  } div_status_t;

endpackage

/* hdl/pdl_mul.sv */
// shared signed multiplier with registered product
// depends on pdl_pkg for operand and product widths
module pdl_mul
  import pdl_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

/* hdl/pdl_div.sv */
// radix-4 restoring divider: CLOCK_RATE / rate, two quotient bits a cycle
// depends on pdl_pkg; saturates the quotient to the period width
module pdl_div
  import pdl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_cmd_t    cmd,
  output div_status_t status
);

  logic [DIV_PAD-1:0]   num;
  logic [DIV_PAD-1:0]   quo;
  logic [LEVEL_W-1:0]   rem;
  rate_t                dv;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [LEVEL_W:0]   t1, t2, d1, d2;
  logic               ge1, ge2;
  logic [LEVEL_W-1:0] r1, r2;

  always_comb begin
    t1  = {rem, num[DIV_PAD-1]};
    d1  = t1 - {1'b0, dv};
    ge1 = t1 >= {1'b0, dv};
    r1  = ge1 ? d1[LEVEL_W-1:0] : t1[LEVEL_W-1:0];
    t2  = {r1, num[DIV_PAD-2]};
    d2  = t2 - {1'b0, dv};
    ge2 = t2 >= {1'b0, dv};
    r2  = ge2 ? d2[LEVEL_W-1:0] : t2[LEVEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        num  <= DIV_PAD'(CLOCK_RATE);
        quo  <= '0;
        rem  <= '0;
        dv   <= cmd.divisor;
      end else if (busy) begin
        num <= {num[DIV_PAD-3:0], 2'b00};
        quo <= {quo[DIV_PAD-3:0], ge1, ge2};
        rem <= r2;
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // zero divisor gives all ones, which saturates as well
  assign status.done   = done;
  assign status.period = (|quo[DIV_PAD-1:PERIOD_W]) ? {PERIOD_W{1'b1}} : quo[PERIOD_W-1:0];

endmodule

/* hdl/pd_line_follow_step_rate.sv */
// line follower pd controller: sequencer, shared adder, config registers
// depends on pdl_pkg, pdl_mul and pdl_div
//
// usage:
//   input channel (in_valid/in_ready) takes one transaction of three 12-bit
//   sensor levels; output channel (out_valid/out_ready) returns the left and
//   right step periods, their high times and limit_flag.
//   in_ready is high only while the sequencer is idle. one transaction
//   passes through eight arithmetic steps on a shared 22x19 multiplier and a
//   48-bit adder, one clamp step, then two divisions of 11 radix-4 steps
//   and one output step; the two divisions take most of the sequence, and
//   the next transaction is taken only once the sequencer is idle again.
//   the result sits in an output register, so the next transaction is
//   accepted while it waits; if the receiver still holds the previous
//   result when the next one is done, the sequencer waits in its last step.
//   apb registers at byte address 4*i; writes land when psel, penable and
//   pwrite are high (pready is always high). write only while idle.
//   synchronous reset returns registers to defaults, clears the stored
//   error and drops out_valid.
module pd_line_follow_step_rate
  import pdl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [LEVEL_W-1:0]  left_level,
  input  logic [LEVEL_W-1:0]  centre_level,
  input  logic [LEVEL_W-1:0]  right_level,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PERIOD_W-1:0] left_step_period,
  output logic [HIGH_W-1:0]   left_high_time,
  output logic [PERIOD_W-1:0] right_step_period,
  output logic [HIGH_W-1:0]   right_high_time,
  output logic                limit_flag,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_KP    = 4'd1;
  localparam logic [3:0] S_KD    = 4'd2;
  localparam logic [3:0] S_CORR  = 4'd3;
  localparam logic [3:0] S_XHI   = 4'd4;
  localparam logic [3:0] S_XLO   = 4'd5;
  localparam logic [3:0] S_XSUM  = 4'd6;
  localparam logic [3:0] S_RR    = 4'd7;
  localparam logic [3:0] S_LR    = 4'd8;
  localparam logic [3:0] S_CLAMP = 4'd9;
  localparam logic [3:0] S_DIVL  = 4'd10;
  localparam logic [3:0] S_DIVR  = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0] state, state_next;

  logic [LEVEL_W-1:0] centre_target, left_edge_target, right_edge_target;
  logic [GAIN_W-1:0]  proportional_gain, derivative_gain;
  rate_t              cruise_step_rate, lowest_step_rate, highest_step_rate;

  logic signed [ERR_W-1:0]  last_error;
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic                     left_low, right_low;

  logic signed [ACC_W-1:0] acc;
  logic signed [RAW_W-1:0] rate_r_raw, rate_l_raw;
  rate_t                   rate_r_fin;
  logic                    flag;
  logic [PERIOD_W-1:0]     lp;

  logic signed [ERR_W-1:0] err_new;

  // shared multiplier
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [ACC_W-1:0]   prod_ext;

  // shared adder
  logic [ACC_W-1:0] add_a, add_b, sum;
  logic             add_sub;
  logic [ACC_W-1:0] cruise_one;

  // clamp and final rate selection
  logic  clamp_l, clamp_r;
  rate_t rate_l_clamped, rate_r_clamped, lfin, rfin;

  div_cmd_t    div_cmd;
  div_status_t div_status;

  logic cfg_write;

  pdl_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pdl_div u_div (
    .clk    (clk),
    .rst    (rst),
    .cmd    (div_cmd),
    .status (div_status)
  );

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_target     <= 12'd3102;
      left_edge_target  <= 12'd3412;
      right_edge_target <= 12'd3102;
      proportional_gain <= 20'd1056;
      derivative_gain   <= 20'd85;
      cruise_step_rate  <= 12'd218;
      lowest_step_rate  <= 12'd85;
      highest_step_rate <= 12'd351;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_CENTRE_TARGET: centre_target     <= pwdata[LEVEL_W-1:0];
        REG_LEFT_TARGET:   left_edge_target  <= pwdata[LEVEL_W-1:0];
        REG_RIGHT_TARGET:  right_edge_target <= pwdata[LEVEL_W-1:0];
        REG_PROP_GAIN:     proportional_gain <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:    derivative_gain   <= pwdata[GAIN_W-1:0];
        REG_CRUISE_RATE:   cruise_step_rate  <= pwdata[LEVEL_W-1:0];
        REG_LOWEST_RATE:   lowest_step_rate  <= pwdata[LEVEL_W-1:0];
        REG_HIGHEST_RATE:  highest_step_rate <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_CENTRE_TARGET: prdata = DATA_W'(centre_target);
      REG_LEFT_TARGET:   prdata = DATA_W'(left_edge_target);
      REG_RIGHT_TARGET:  prdata = DATA_W'(right_edge_target);
      REG_PROP_GAIN:     prdata = DATA_W'(proportional_gain);
      REG_DERIV_GAIN:    prdata = DATA_W'(derivative_gain);
      REG_CRUISE_RATE:   prdata = DATA_W'(cruise_step_rate);
      REG_LOWEST_RATE:   prdata = DATA_W'(lowest_step_rate);
      REG_HIGHEST_RATE:  prdata = DATA_W'(highest_step_rate);
      default:           prdata = '0;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign err_new  = $signed({1'b0, centre_level}) - $signed({1'b0, centre_target});

  // multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      S_KP: begin
        mul_en = 1'b1;
        mul_a  = $signed({2'b00, proportional_gain});
        mul_b  = MUL_B_W'(err);
      end
      S_KD: begin
        mul_en = 1'b1;
        mul_a  = $signed({2'b00, derivative_gain});
        mul_b  = MUL_B_W'(diff);
      end
      S_XHI: begin
        mul_en = 1'b1;
        mul_a  = $signed({10'd0, cruise_step_rate});
        mul_b  = {{2{acc[CORR_W-1]}}, acc[CORR_W-1:CORR_LO_W]};
      end
      S_XLO: begin
        mul_en = 1'b1;
        mul_a  = $signed({10'd0, cruise_step_rate});
        mul_b  = $signed({1'b0, acc[CORR_LO_W-1:0]});
      end
      default: ;
    endcase
  end

  assign prod_ext   = ACC_W'(prod);
  assign cruise_one = ACC_W'({cruise_step_rate, {FRAC_BITS{1'b0}}});

  // adder operand select
  always_comb begin
    add_a   = '0;
    add_b   = prod_ext;
    add_sub = 1'b0;
    unique case (state)
      S_CORR: begin
        add_a   = acc;
        add_sub = 1'b1;
      end
      S_XSUM: add_a = {acc[ACC_W-CORR_LO_W-1:0], {CORR_LO_W{1'b0}}};
      S_RR: begin
        add_a = cruise_one;
        add_b = acc;
      end
      S_LR: begin
        add_a   = cruise_one;
        add_b   = acc;
        add_sub = 1'b1;
      end
      default: ;
    endcase
    sum = add_a + (add_b ^ {ACC_W{add_sub}}) + ACC_W'(add_sub);
  end

  // clamp both rates, then apply edge overrides
  always_comb begin
    clamp_r = 1'b1;
    clamp_l = 1'b1;
    if (rate_r_raw <= $signed(RAW_W'(lowest_step_rate))) begin
      rate_r_clamped = lowest_step_rate;
    end else if (rate_r_raw >= $signed(RAW_W'(highest_step_rate))) begin
      rate_r_clamped = highest_step_rate;
    end else begin
      rate_r_clamped = rate_r_raw[LEVEL_W-1:0];
      clamp_r        = 1'b0;
    end
    if (rate_l_raw <= $signed(RAW_W'(lowest_step_rate))) begin
      rate_l_clamped = lowest_step_rate;
    end else if (rate_l_raw >= $signed(RAW_W'(highest_step_rate))) begin
      rate_l_clamped = highest_step_rate;
    end else begin
      rate_l_clamped = rate_l_raw[LEVEL_W-1:0];
      clamp_l        = 1'b0;
    end
    if (right_low) begin
      lfin = highest_step_rate;
      rfin = lowest_step_rate;
    end else if (left_low) begin
      lfin = lowest_step_rate;
      rfin = highest_step_rate;
    end else begin
      lfin = rate_l_clamped;
      rfin = rate_r_clamped;
    end
  end

  assign div_cmd.start   = (state == S_CLAMP) || (state == S_DIVL && div_status.done);
  assign div_cmd.divisor = (state == S_CLAMP) ? lfin : rate_r_fin;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_KP;
      S_KP:    state_next = S_KD;
      S_KD:    state_next = S_CORR;
      S_CORR:  state_next = S_XHI;
      S_XHI:   state_next = S_XLO;
      S_XLO:   state_next = S_XSUM;
      S_XSUM:  state_next = S_RR;
      S_RR:    state_next = S_LR;
      S_LR:    state_next = S_CLAMP;
      S_CLAMP: state_next = S_DIVL;
      S_DIVL:  if (div_status.done) state_next = S_DIVR;
      S_DIVR:  if (div_status.done) state_next = S_FIN;
      S_FIN:   if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      last_error <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        last_error <= err_new;
      end
      if (state == S_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      err       <= err_new;
      diff      <= DIFF_W'(err_new) - DIFF_W'(last_error);
      left_low  <= left_level < left_edge_target;
      right_low <= right_level < right_edge_target;
    end
    if (state == S_KD || state == S_CORR || state == S_XLO || state == S_XSUM) begin
      acc <= sum;
    end
    if (state == S_RR) begin
      rate_r_raw <= sum[ACC_W-1:FRAC_BITS];
    end
    if (state == S_LR) begin
      rate_l_raw <= sum[ACC_W-1:FRAC_BITS];
    end
    if (state == S_CLAMP) begin
      rate_r_fin <= rfin;
      flag       <= clamp_l || clamp_r || left_low || right_low;
    end
    if (state == S_DIVL && div_status.done) begin
      lp <= div_status.period;
    end
    if (state == S_FIN && (!out_valid || out_ready)) begin
      left_step_period  <= lp;
      left_high_time    <= (left_low && !right_low) ? '0 : lp[PERIOD_W-1:1];
      right_step_period <= div_status.period;
      right_high_time   <= right_low ? '0 : div_status.period[PERIOD_W-1:1];
      limit_flag        <= flag;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer took a transaction while busy");

  assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> (state == S_DIVL || state == S_DIVR))
    else $error("divider finished outside a division step");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_high_time == left_step_period[PERIOD_W-1:1] || left_high_time == '0))
    else $error("left high time is neither half period nor zero");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (left_high_time == '0 || right_high_time == '0) |-> limit_flag)
    else $error("forced turn without limit flag");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(left_high_time == '0 && right_high_time == '0))
    else $error("both motors stopped");

endmodule
